@@ rtl/mt_rng_pkg.sv @@
// ----------------------------------------------------------------------------
// mt_rng_pkg
// Constants, codes, state type and tempering function of the MT19937 block.
// ----------------------------------------------------------------------------
package mt_rng_pkg;

    localparam int unsigned MT_DEPTH = 624;
    localparam int unsigned ADDR_W   = $clog2(MT_DEPTH);

    localparam logic [ADDR_W-1:0] MT_N    = ADDR_W'(624);
    localparam logic [ADDR_W-1:0] MT_LAST = ADDR_W'(623);
    localparam logic [ADDR_W-1:0] MT_M    = ADDR_W'(397);
    localparam logic [ADDR_W-1:0] MT_NM   = ADDR_W'(227);

    localparam logic [31:0] MT_UPPER  = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER  = 32'h7fff_ffff;
    localparam logic [31:0] MT_MAGIC  = 32'h9908_b0df;
    localparam logic [31:0] MT_TMASKB = 32'h9d2c_5680;
    localparam logic [31:0] MT_TMASKC = 32'hefc6_0000;
    localparam logic [31:0] MT_BASE   = 32'd19650218;
    localparam logic [31:0] MUL_LIN   = 32'd1812433253;
    localparam logic [31:0] MUL_MIX1  = 32'd1664525;
    localparam logic [31:0] MUL_MIX2  = 32'd1566083941;

    localparam logic [1:0] CMD_SEED_LIN = 2'd0;
    localparam logic [1:0] CMD_SEED_ARR = 2'd1;
    localparam logic [1:0] CMD_DRAW     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIN_MUL,
        S_LIN_WR,
        S_ARR_RD,
        S_ARR_WR,
        S_ARR_W0,
        S_ARR_FIX,
        S_TW_R0,
        S_TW_RN,
        S_TW_RF,
        S_TW_WR,
        S_DRAW_RA,
        S_DRAW_RD,
        S_OUT
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TMASKB);
        y = y ^ ((y << 15) & MT_TMASKC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ rtl/mt_req_if.sv @@
// ----------------------------------------------------------------------------
// mt_req_if
// Command channel: valid/ready handshake with command code and seed word.
// ----------------------------------------------------------------------------
interface mt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] seed_value;

    modport source (output valid, output cmd, output seed_value, input ready);
    modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

@@ rtl/mt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mt_rsp_if
// Result channel: valid/ready handshake with tempered word and error flag.
// ----------------------------------------------------------------------------
interface mt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] rand_word;
    logic        not_seeded;

    modport source (output valid, output rand_word, output not_seeded, input ready);
    modport sink (input valid, input rand_word, input not_seeded, output ready);
endinterface

@@ rtl/mersenne_twister_rng.sv @@
// a draw runs S_DRAW_RA (ram read), S_DRAW_RD (temper) and S_OUT, which waits for a free
// output register; if the 624 words are regenerated first, the twist runs S_TW_R0, then
// S_TW_RN, S_TW_RF, S_TW_WR per word; linear seed runs S_LIN_MUL, S_LIN_WR per word;
// array seed adds two mixing passes of S_ARR_RD, S_ARR_WR; one multiplier, one ram port,
// one command at a time; a result waits in the output register while the next is taken
// reset clears the sequencer, index (624), seeded flag and twist select; ram is not cleared
// ----------------------------------------------------------------------------
// mersenne_twister_rng
// MT19937 generator: linear and one-word-array seeding, tempered draws,
// in-place twist through a single ram under a small sequencer.
// ----------------------------------------------------------------------------
module mersenne_twister_rng (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    mt_req_if.sink   req,
    mt_rsp_if.source rsp
);
    import mt_rng_pkg::*;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] n_reg, n_next;
    logic [ADDR_W:0]   idx_reg, idx_next;
    logic              seeded_reg, seeded_next;
    logic              legacy_reg;
    logic              arr_reg, arr_next;
    logic              pass_reg, pass_next;
    logic [31:0]       p_reg, p_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       nxt_reg, nxt_next;
    logic [31:0]       res_reg, res_next;
    logic              res_ns_reg, res_ns_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_word_reg, out_word_next;
    logic              out_ns_reg, out_ns_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    logic [31:0] mul_a, mul_k, mul_p, mix_v, y_tw, tw_v;
    logic [ADDR_W-1:0] far_addr;
    logic sel_tw;

    mt_ram #(.WIDTH(32), .DEPTH(MT_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiplier: constant chosen by the phase
    assign mul_a = p_reg ^ (p_reg >> 30);
    assign mul_k = (state_reg == S_LIN_MUL) ? MUL_LIN : (pass_reg ? MUL_MIX2 : MUL_MIX1);
    assign mul_p = 32'(mul_a * mul_k);

    assign mix_v = pass_reg ? ((ram_rdata ^ prod_reg) - {{(32-ADDR_W){1'b0}}, i_reg})
                            : ((ram_rdata ^ prod_reg) + key_reg);

    assign far_addr = (i_reg < MT_NM) ? (i_reg + MT_M) : (i_reg - MT_NM);
    assign y_tw     = (cur_reg & MT_UPPER) | (nxt_reg & MT_LOWER);
    assign sel_tw   = legacy_reg ? cur_reg[0] : y_tw[0];
    assign tw_v     = ram_rdata ^ (y_tw >> 1) ^ (sel_tw ? MT_MAGIC : 32'd0);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.rand_word  = out_word_reg;
    assign rsp.not_seeded = out_ns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= {1'b0, MT_N};
            seeded_reg    <= 1'b0;
            legacy_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            arr_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            i_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            arr_reg       <= arr_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            if (cfg_wr_en)
            begin
                legacy_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        key_reg      <= key_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        res_reg      <= res_next;
        res_ns_reg   <= res_ns_next;
        out_word_reg <= out_word_next;
        out_ns_reg   <= out_ns_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        seeded_next    = seeded_reg;
        arr_next       = arr_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        key_next       = key_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        res_next       = res_reg;
        res_ns_next    = res_ns_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_ns_next    = out_ns_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_reg;
        ram_wdata      = p_reg;
        ram_raddr      = i_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd)
                        CMD_SEED_LIN, CMD_SEED_ARR:
                        begin
                            // word 0 of the linear fill
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = (req.cmd == CMD_SEED_ARR) ? MT_BASE : req.seed_value;
                            p_next    = ram_wdata;
                            key_next  = req.seed_value;
                            arr_next  = (req.cmd == CMD_SEED_ARR);
                            i_next    = ADDR_W'(1);
                            state_next = S_LIN_MUL;
                        end
                        CMD_DRAW:
                        begin
                            if (!seeded_reg)
                            begin
                                res_next    = '0;
                                res_ns_next = 1'b1;
                                state_next  = S_OUT;
                            end
                            else if (idx_reg >= {1'b0, MT_N})
                            begin
                                i_next     = '0;
                                state_next = S_TW_R0;
                            end
                            else
                            begin
                                state_next = S_DRAW_RA;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LIN_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_LIN_WR;
            end
            S_LIN_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = prod_reg + {{(32-ADDR_W){1'b0}}, i_reg};
                p_next    = ram_wdata;
                if (i_reg == MT_LAST)
                begin
                    if (arr_reg)
                    begin
                        p_next     = MT_BASE;
                        i_next     = ADDR_W'(1);
                        n_next     = '0;
                        pass_next  = 1'b0;
                        state_next = S_ARR_RD;
                    end
                    else
                    begin
                        seeded_next = 1'b1;
                        idx_next    = {1'b0, MT_N};
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = S_LIN_MUL;
                end
            end
            S_ARR_RD:
            begin
                prod_next  = mul_p;
                state_next = S_ARR_WR;
            end
            S_ARR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = mix_v;
                p_next    = mix_v;
                n_next    = n_reg + ADDR_W'(1);
                i_next    = i_reg + ADDR_W'(1);
                state_next = S_ARR_RD;
                if (i_reg == MT_LAST)
                begin
                    // wrap: copy the last word into word 0
                    i_next     = ADDR_W'(1);
                    state_next = S_ARR_W0;
                end
                if (!pass_reg && n_reg == MT_LAST)
                begin
                    pass_next = 1'b1;
                    n_next    = '0;
                end
                else if (pass_reg && n_reg == ADDR_W'(MT_LAST - ADDR_W'(1)))
                begin
                    state_next = S_ARR_FIX;
                end
            end
            S_ARR_W0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                state_next = S_ARR_RD;
            end
            S_ARR_FIX:
            begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = MT_UPPER;
                seeded_next = 1'b1;
                idx_next    = {1'b0, MT_N};
                state_next  = S_IDLE;
            end
            S_TW_R0:
            begin
                ram_raddr  = '0;
                state_next = S_TW_RN;
            end
            S_TW_RN:
            begin
                if (i_reg == '0)
                begin
                    cur_next = ram_rdata;
                end
                ram_raddr  = (i_reg == MT_LAST) ? '0 : (i_reg + ADDR_W'(1));
                state_next = S_TW_RF;
            end
            S_TW_RF:
            begin
                nxt_next   = ram_rdata;
                ram_raddr  = far_addr;
                state_next = S_TW_WR;
            end
            S_TW_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = tw_v;
                cur_next  = nxt_reg;
                if (i_reg == MT_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_DRAW_RA;
                end
                else
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = S_TW_RN;
                end
            end
            S_DRAW_RA:
            begin
                ram_raddr  = idx_reg[ADDR_W-1:0];
                state_next = S_DRAW_RD;
            end
            S_DRAW_RD:
            begin
                res_next    = temper(ram_rdata);
                res_ns_next = 1'b0;
                idx_next    = idx_reg + (ADDR_W+1)'(1);
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    out_ns_next    = res_ns_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_ns_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.not_seeded |-> rsp.rand_word == 32'd0)
        else $error("not_seeded word is not zero");

    a_draw_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAW_RA |-> idx_reg < {1'b0, MT_N} && seeded_reg)
        else $error("draw read with index out of range");

    a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ARR_FIX |=> seeded_reg && idx_reg == {1'b0, MT_N})
        else $error("array seed did not finish cleanly");

    a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TW_WR && i_reg == MT_LAST |=> state_reg == S_DRAW_RA && idx_reg == '0)
        else $error("twist did not hand over to the draw");

    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.cmd == CMD_DRAW |=> !req.ready)
        else $error("draw accepted without going busy");
endmodule

@@ rtl/mt_ram.sv @@
// ----------------------------------------------------------------------------
// mt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
